FILE: rtl/ecds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecds_pkg
// Shared widths, register indexes, reset values and result path codes for
// the credit delay shaper.
// ----------------------------------------------------------------------------
package ecds_pkg;

  localparam int CREDIT_W    = 24;
  localparam int UNIT_W      = 16;
  localparam int DELAY_W     = 35;
  localparam int FIELD_LEN_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_REFILL_AMOUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CREDIT_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_DELAY      = 2'd2;

  localparam logic [CREDIT_W-1:0] REFILL_RESET   = 24'd10000;
  localparam logic [CREDIT_W-1:0] CAPACITY_RESET = 24'd250000;
  localparam logic [UNIT_W-1:0]   UNIT_RESET     = 16'd1000;

  localparam logic MODE_TICK = 1'b1;

  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  typedef enum logic [1:0] {
    PATH_ENOUGH  = 2'd0,
    PATH_NONE    = 2'd1,
    PATH_PARTIAL = 2'd2,
    PATH_TICK    = 2'd3
  } path_t;

endpackage
`default_nettype wire

FILE: rtl/entanglement_credit_delay_shaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// entanglement_credit_delay_shaper
// Token bucket delay shaper: credit store, per-packet cost and delay.
// ----------------------------------------------------------------------------
// Each item is either a packet length (mode 0) or a refill tick (mode 1).
// The block takes one item per clock while item_stall is low and returns
// exactly one result per item, in order, passing through an input
// register, a credit/cost stage, and a multiply stage that loads the
// result register. The credit register is read and rewritten in the one
// credit/cost stage, so the credit loop (a 25-bit compare, a subtract and a
// saturating add) is what sets the one-item-per-cycle rate; the cost-by-unit
// multiply sits in its own stage. A packet below twice the credit costs 4 units
// per byte and spends half its length in credit; with zero credit it costs 8
// per byte; otherwise the credit covers twice its value in bytes at 2 units,
// the rest costs 8 per byte and the credit goes to zero. The delay is the cost
// times unit_delay, saturated at the top of the 35-bit field. A tick adds
// refill_amount and clamps at credit_capacity (which can also lower the
// credit). item_stall rises only when all three stages hold items and the
// result is stalled; a bubble anywhere lets a new item in. Configuration
// writes are always ready and should land only while the block is empty.
// Packet lengths are taken in their low LENGTH_WIDTH bits (16 at most).
module entanglement_credit_delay_shaper #(
  parameter int LENGTH_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // item channel
  input  wire logic                                 item_valid,
  output logic                                      item_stall,
  input  wire logic                                 mode,
  input  wire logic [ecds_pkg::FIELD_LEN_W-1:0]     packet_length,
  // result channel
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic [ecds_pkg::DELAY_W-1:0]              delay_ns,
  output logic [ecds_pkg::CREDIT_W-1:0]             credit_after,
  output logic [1:0]                                path,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ecds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ecds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Effective length bits: the field is 16 bits, the parameter may narrow it.
  localparam int LenBits = (LENGTH_WIDTH < ecds_pkg::FIELD_LEN_W) ?
                           LENGTH_WIDTH : ecds_pkg::FIELD_LEN_W;
  // Cost is at most 8 units per byte.
  localparam int CostW   = LenBits + 3;
  localparam int ProdW   = CostW + ecds_pkg::UNIT_W;
  localparam int WideW   = (ProdW > ecds_pkg::DELAY_W) ? ProdW : ecds_pkg::DELAY_W;
  localparam int CW      = ecds_pkg::CREDIT_W;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; index three is ignored.
  // --------------------------------------------------------------------------
  logic [CW-1:0]                  refill_amount;
  logic [CW-1:0]                  credit_capacity;
  logic [ecds_pkg::UNIT_W-1:0]    unit_delay;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      refill_amount   <= ecds_pkg::REFILL_RESET;
      credit_capacity <= ecds_pkg::CAPACITY_RESET;
      unit_delay      <= ecds_pkg::UNIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ecds_pkg::REG_REFILL_AMOUNT:   refill_amount   <= cfg_data;
        ecds_pkg::REG_CREDIT_CAPACITY: credit_capacity <= cfg_data;
        ecds_pkg::REG_UNIT_DELAY:      unit_delay      <= cfg_data[ecds_pkg::UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage moves on when the one after it is empty
  // or moving on itself.
  // --------------------------------------------------------------------------
  logic s0_valid;
  logic s1_valid;
  logic out_ready;
  logic s1_ready;
  logic s0_ready;
  logic s0_move;
  logic s1_move;

  assign out_ready  = !result_valid || !result_stall;
  assign s1_ready   = !s1_valid || out_ready;
  assign s0_ready   = !s0_valid || s1_ready;
  assign s0_move    = s0_valid && s1_ready;
  assign s1_move    = s1_valid && out_ready;
  assign item_stall = !s0_ready;

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  logic               s0_tick;
  logic [LenBits-1:0] s0_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= item_valid;
    end
    if (item_valid && s0_ready) begin
      s0_tick <= (mode == ecds_pkg::MODE_TICK);
      s0_len  <= packet_length[LenBits-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: credit update and cost. The credit register changes only when
  // the item in stage 0 moves on, so updates follow item order.
  // --------------------------------------------------------------------------
  logic [CW-1:0]    credit;
  logic [CW-1:0]    credit_next;
  logic [CostW-1:0] cost_next;
  ecds_pkg::path_t  path_next;

  logic [CW:0]      two_credit;
  logic [CW:0]      refill_sum;
  logic [LenBits-1:0] len_rest;
  logic [CostW-1:0] credit_cost;

  always_comb begin
    two_credit  = {credit, 1'b0};
    refill_sum  = {1'b0, credit} + {1'b0, refill_amount};
    // Only meaningful on the partial path, where 2*credit <= length.
    len_rest    = s0_len - LenBits'(two_credit);
    credit_cost = CostW'(credit) << 2;
    credit_next = credit;
    cost_next   = '0;
    path_next   = ecds_pkg::PATH_TICK;
    if (s0_tick) begin
      // Refill: add and clamp at capacity.
      credit_next = (refill_sum > {1'b0, credit_capacity}) ?
                    credit_capacity : refill_sum[CW-1:0];
    end else if ((CW+1)'(s0_len) < two_credit) begin
      // Enough credit: 4 per byte, spend half the length.
      credit_next = credit - CW'(s0_len >> 1);
      cost_next   = CostW'(s0_len) << 2;
      path_next   = ecds_pkg::PATH_ENOUGH;
    end else if (credit == '0) begin
      // No credit: 8 per byte.
      cost_next   = CostW'(s0_len) << 3;
      path_next   = ecds_pkg::PATH_NONE;
    end else begin
      // Partial: credit covers 2*credit bytes, the rest at full price.
      credit_next = '0;
      cost_next   = credit_cost + (CostW'(len_rest) << 3);
      path_next   = ecds_pkg::PATH_PARTIAL;
    end
  end

  logic [CostW-1:0] s1_cost;
  logic [CW-1:0]    s1_credit;
  ecds_pkg::path_t  s1_path;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      credit   <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
      if (s0_move) begin
        credit <= credit_next;
      end
    end
    if (s0_move) begin
      s1_cost   <= cost_next;
      s1_credit <= credit_next;
      s1_path   <= path_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cost times unit delay, saturate, load the result register.
  // --------------------------------------------------------------------------
  logic [WideW-1:0]            prod_wide;
  logic [ecds_pkg::DELAY_W-1:0] delay_next;

  always_comb begin
    prod_wide  = WideW'(s1_cost) * WideW'(unit_delay);
    delay_next = (prod_wide > WideW'(ecds_pkg::DELAY_MAX)) ?
                 ecds_pkg::DELAY_MAX : prod_wide[ecds_pkg::DELAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= s1_valid;
    end
    if (s1_move) begin
      delay_ns     <= delay_next;
      credit_after <= s1_credit;
      path         <= s1_path;
    end
  end

`ifndef NO_ASSERTIONS
  // A tick never carries a delay.
  a_tick_no_delay: assert property (@(posedge clk) disable iff (rst)
    result_valid && (path == ecds_pkg::PATH_TICK) |-> (delay_ns == '0))
    else $error("tick result with nonzero delay");

  // The no-credit and partial paths both leave the credit empty.
  a_empty_after_spend: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((path == ecds_pkg::PATH_NONE) || (path == ecds_pkg::PATH_PARTIAL))
    |-> (credit_after == '0))
    else $error("credit left after a no-credit or partial packet");

  // The credit register changes only when an item leaves stage 0.
  a_credit_moves_with_item: assert property (@(posedge clk) disable iff (rst)
    !s0_move |=> $stable(credit))
    else $error("credit changed without an item");

  // Input is held off only when every stage is full and the result stalled.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s0_valid && s1_valid && result_valid && result_stall))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire
